>>> rtl/core/lzfd_pkg.sv
package lzfd_pkg;

    localparam int unsigned LEN_W    = 24;
    localparam int unsigned OFS_W    = 12;
    localparam int unsigned CNT_W    = 5;
    localparam logic [CNT_W-1:0] LEN_BIAS = CNT_W'(3);

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DIST  = 2'd1,
        ST_EARLY = 2'd2,
        ST_HDR   = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       finished;
        t_status    status;
    } t_result;

endpackage

>>> rtl/core/lzfd_if.sv
interface lzfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       source_end;

    modport source (output valid, output stream_byte, output source_end, input ready);
    modport sink   (input valid, input stream_byte, input source_end, output ready);
endinterface

interface lzfd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       finished;
    logic [1:0] status;

    modport source (output valid, output out_byte, output has_byte, output finished,
                    output status, input ready);
    modport sink   (input valid, input out_byte, input has_byte, input finished,
                    input status, output ready);
endinterface

>>> rtl/core/lzfd_hist.sv
module lzfd_hist #(
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [7:0]               i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [7:0]               o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/lz77_flagged_decompressor_top.sv
// lz77 (lz10 style) stream decompressor
// i_in takes the compressed source one byte per transfer, header included,
// with source_end set on the last byte. o_out gives one result per transfer:
// a decoded byte (has_byte) or a status-only result, finished on the last
// result of a stream.
// a copy pair is taken as its high byte, then its low byte; the length
// is 3 to 18 bytes, cut short where the stream length is reached. each
// copied byte passes through S_RD for the registered history read and
// S_EMIT, which writes it back and presents it through the single byte
// emit path shared with literals, and waits there while the output is full.
// the block takes no byte while a copy runs; a byte that ends the source
// early gets its status result from a separate tail state.
// results sit in one output register; a byte is taken only when that
// register is free or being drained, so a stalled receiver stalls the
// input side and nothing is lost.
// reset empties the output register and starts a fresh stream at the
// header; history contents are not cleared and are only read after being
// written within the same stream.
module lz77_flagged_decompressor_top
    import lzfd_pkg::*;
#(
    parameter int unsigned HISTORY_DEPTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lzfd_in_if.sink     i_in,
    lzfd_out_if.source  o_out
);

    localparam int unsigned AW = $clog2(HISTORY_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_EMIT,
        S_TAIL
    } t_state;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_BODY,
        PH_PAIR_LOW
    } t_phase;

    t_state           r_state, n_state;
    t_phase           r_phase, n_phase;
    logic [AW-1:0]    r_wp, n_wp;
    logic [AW-1:0]    r_rd, n_rd;
    logic [LEN_W-1:0] r_prod, n_prod;
    logic [LEN_W-1:0] r_left, n_left;
    logic [2:0]       r_hidx, n_hidx;
    logic [7:0]       r_flags, n_flags;
    logic [3:0]       r_fleft, n_fleft;
    logic [7:0]       r_pair_high, n_pair_high;
    logic             r_done, n_done;
    logic             r_end, n_end;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_ov, n_ov;
    t_result          r_res, n_res;

    logic             can_put;
    logic             acc;
    logic             put_v;
    t_result          put_res;
    logic             emit_v;
    logic [7:0]       emit_b;
    logic             hdr_closed;
    logic             closed;
    logic             do_finish;
    logic             fin_end;
    logic             restart;
    logic             we;
    logic [7:0]       rdata;
    logic [OFS_W:0]   span;

    lzfd_hist #(
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_wp),
        .i_wdata (emit_b),
        .i_raddr (r_rd),
        .o_rdata (rdata)
    );

    assign can_put    = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && can_put;
    assign acc        = i_in.valid && i_in.ready;
    assign span       = {1'b0, r_pair_high[3:0], i_in.stream_byte} + (OFS_W + 1)'(1);

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_wp        = r_wp;
        n_rd        = r_rd;
        n_prod      = r_prod;
        n_left      = r_left;
        n_hidx      = r_hidx;
        n_flags     = r_flags;
        n_fleft     = r_fleft;
        n_pair_high = r_pair_high;
        n_done      = r_done;
        n_end       = r_end;
        n_cnt       = r_cnt;
        put_v       = 1'b0;
        put_res     = '0;
        emit_v      = 1'b0;
        emit_b      = rdata;
        hdr_closed  = 1'b0;
        do_finish   = 1'b0;
        fin_end     = 1'b0;
        restart     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (r_done) begin
                        restart = i_in.source_end;
                    end else begin
                        do_finish = 1'b1;
                        fin_end   = i_in.source_end;
                        case (r_phase)
                            PH_BODY: begin
                                if (r_fleft == 4'd0) begin
                                    n_flags = i_in.stream_byte;
                                    n_fleft = 4'd8;
                                end else begin
                                    n_flags = {r_flags[6:0], 1'b0};
                                    n_fleft = r_fleft - 4'd1;
                                    if (r_flags[7]) begin
                                        n_pair_high = i_in.stream_byte;
                                        n_phase     = PH_PAIR_LOW;
                                    end else begin
                                        emit_v = 1'b1;
                                        emit_b = i_in.stream_byte;
                                    end
                                end
                            end
                            PH_PAIR_LOW: begin
                                n_phase = PH_BODY;
                                if (LEN_W'(span) > r_prod) begin
                                    put_v          = 1'b1;
                                    put_res.status = ST_DIST;
                                    n_fleft        = 4'd0;
                                end else begin
                                    do_finish = 1'b0;
                                    n_rd      = r_wp - AW'(span);
                                    n_cnt     = CNT_W'(r_pair_high[7:4]) + LEN_BIAS;
                                    n_end     = i_in.source_end;
                                    n_state   = S_RD;
                                end
                            end
                            default: begin
                                case (r_hidx)
                                    3'd1: n_left[7:0]   = i_in.stream_byte;
                                    3'd2: n_left[15:8]  = i_in.stream_byte;
                                    3'd3: n_left[23:16] = i_in.stream_byte;
                                    default: ;
                                endcase
                                n_hidx = r_hidx + 3'd1;
                                if (r_hidx == 3'd3) begin
                                    if (n_left == '0) begin
                                        hdr_closed = 1'b1;
                                    end else begin
                                        n_phase = PH_BODY;
                                        n_fleft = 4'd0;
                                    end
                                end else if (i_in.source_end) begin
                                    hdr_closed = 1'b1;
                                end
                                if (hdr_closed) begin
                                    put_v            = 1'b1;
                                    put_res.finished = 1'b1;
                                    put_res.status   = ST_HDR;
                                end
                            end
                        endcase
                    end
                end
            end
            S_RD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (can_put) begin
                    emit_v = 1'b1;
                    n_rd   = r_rd + AW'(1);
                    n_cnt  = r_cnt - CNT_W'(1);
                    if (r_left == LEN_W'(1) || r_cnt == CNT_W'(1)) begin
                        do_finish = 1'b1;
                        fin_end   = r_end;
                        n_state   = S_IDLE;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_TAIL: begin
                if (can_put) begin
                    put_v            = 1'b1;
                    put_res.finished = 1'b1;
                    put_res.status   = ST_EARLY;
                    restart          = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // shared byte emit path
        if (emit_v) begin
            n_wp             = r_wp + AW'(1);
            n_prod           = r_prod + LEN_W'(1);
            n_left           = r_left - LEN_W'(1);
            put_v            = 1'b1;
            put_res.out_byte = emit_b;
            put_res.has_byte = 1'b1;
            put_res.finished = (r_left == LEN_W'(1));
            put_res.status   = ST_OK;
        end

        closed = hdr_closed || (emit_v && r_left == LEN_W'(1));

        if (do_finish) begin
            if (closed) begin
                if (fin_end) begin
                    restart = 1'b1;
                end else begin
                    n_done = 1'b1;
                end
            end else if (fin_end) begin
                n_state = S_TAIL;
            end
        end

        if (restart) begin
            n_phase     = PH_HEADER;
            n_wp        = '0;
            n_prod      = '0;
            n_left      = '0;
            n_hidx      = '0;
            n_flags     = '0;
            n_fleft     = '0;
            n_pair_high = '0;
            n_done      = 1'b0;
        end

        n_ov  = put_v || (r_ov && !o_out.ready);
        n_res = put_v ? put_res : r_res;
    end

    assign we = emit_v;

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_rd  <= n_rd;
        r_cnt <= n_cnt;
        r_end <= n_end;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_HEADER;
            r_wp        <= '0;
            r_prod      <= '0;
            r_left      <= '0;
            r_hidx      <= '0;
            r_flags     <= '0;
            r_fleft     <= '0;
            r_pair_high <= '0;
            r_done      <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_wp        <= n_wp;
            r_prod      <= n_prod;
            r_left      <= n_left;
            r_hidx      <= n_hidx;
            r_flags     <= n_flags;
            r_fleft     <= n_fleft;
            r_pair_high <= n_pair_high;
            r_done      <= n_done;
            r_ov        <= n_ov;
        end
    end

    assign o_out.valid    = r_ov;
    assign o_out.out_byte = r_res.out_byte;
    assign o_out.has_byte = r_res.has_byte;
    assign o_out.finished = r_res.finished;
    assign o_out.status   = r_res.status;

    // a new result never lands on one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        put_v |-> (!r_ov || o_out.ready))
        else $error("result register overwritten");

    // a running copy always has bytes left to move
    a_copy_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD || r_state == S_EMIT) |-> (r_cnt != '0))
        else $error("copy running with zero count");

    // history is written only by a literal or a copied byte
    a_hist_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> ((r_state == S_IDLE && acc) || r_state == S_EMIT))
        else $error("unexpected history write");

    // decoded bytes always carry ok status
    a_byte_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_res.has_byte) |-> (r_res.status == ST_OK))
        else $error("decoded byte with error status");

endmodule

>>> dv/lzfd_checker.sv
`timescale 1ns / 1ps

module lzfd_checker
    import lzfd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    lzfd_in_if   i_in_mon,
    lzfd_out_if  i_out_mon,
    output int   o_fail_count,
    output int   o_owed
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_BODY,
        PH_PAIR_LOW
    } t_phase;

    logic [7:0]  hist [4096];
    logic [11:0] wr_ptr;
    logic [23:0] produced;
    logic [23:0] bytes_left;
    logic [2:0]  hdr_idx;
    logic [7:0]  flags;
    logic [3:0]  flags_left;
    logic [7:0]  pair_hi;
    t_phase      dec_phase;
    logic        awaiting_end;

    t_result     owed_results[$];
    int          fails;

    task automatic restart_stream();
        wr_ptr       = '0;
        produced     = '0;
        bytes_left   = '0;
        hdr_idx      = '0;
        flags        = '0;
        flags_left   = '0;
        pair_hi      = '0;
        dec_phase    = PH_HEADER;
        awaiting_end = 1'b0;
    endtask

    task automatic owe_result(input logic [7:0] b, input logic has, input logic fin,
                              input t_status st);
        t_result r;
        r.out_byte = b;
        r.has_byte = has;
        r.finished = fin;
        r.status   = st;
        owed_results.push_back(r);
    endtask

    task automatic emit_byte(input logic [7:0] b, output logic reached);
        hist[wr_ptr] = b;
        wr_ptr       = wr_ptr + 12'd1;
        produced     = produced + 24'd1;
        bytes_left   = bytes_left - 24'd1;
        reached      = (bytes_left == '0);
        owe_result(b, 1'b1, reached, ST_OK);
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic src_end);
        logic        closed;
        logic        is_pair;
        logic [15:0] pair;
        logic [4:0]  run_len;
        logic [12:0] span;
        logic [11:0] rd;
        logic [7:0]  v;
        int          c;
        closed = 1'b0;
        if (awaiting_end) begin
            if (src_end) restart_stream();
            return;
        end
        case (dec_phase)
            PH_BODY: begin
                if (flags_left == '0) begin
                    flags      = b;
                    flags_left = 4'd8;
                end else begin
                    is_pair    = flags[7];
                    flags      = {flags[6:0], 1'b0};
                    flags_left = flags_left - 4'd1;
                    if (is_pair) begin
                        pair_hi   = b;
                        dec_phase = PH_PAIR_LOW;
                    end else begin
                        emit_byte(b, closed);
                    end
                end
            end
            PH_PAIR_LOW: begin
                pair      = {pair_hi, b};
                run_len   = {1'b0, pair[15:12]} + 5'd3;
                span      = {1'b0, pair[11:0]} + 13'd1;
                dec_phase = PH_BODY;
                if ({11'd0, span} > produced) begin
                    owe_result(8'h00, 1'b0, 1'b0, ST_DIST);
                    flags_left = '0;
                end else begin
                    rd = wr_ptr - span[11:0];
                    for (c = 0; c < int'(run_len) && !closed; c++) begin
                        v  = hist[rd];
                        rd = rd + 12'd1;
                        emit_byte(v, closed);
                    end
                end
            end
            default: begin
                case (hdr_idx)
                    3'd1:    bytes_left[7:0]   = b;
                    3'd2:    bytes_left[15:8]  = b;
                    3'd3:    bytes_left[23:16] = b;
                    default: ;
                endcase
                hdr_idx = hdr_idx + 3'd1;
                if (hdr_idx >= 3'd4) begin
                    if (bytes_left == '0) begin
                        owe_result(8'h00, 1'b0, 1'b1, ST_HDR);
                        closed = 1'b1;
                    end else begin
                        dec_phase  = PH_BODY;
                        flags_left = '0;
                    end
                end else if (src_end) begin
                    owe_result(8'h00, 1'b0, 1'b1, ST_HDR);
                    closed = 1'b1;
                end
            end
        endcase
        if (closed) begin
            if (src_end) restart_stream();
            else awaiting_end = 1'b1;
        end else if (src_end) begin
            owe_result(8'h00, 1'b0, 1'b1, ST_EARLY);
            restart_stream();
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            restart_stream();
            owed_results.delete();
            fails = 0;
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (owed_results.size() == 0) begin
                    $error("unexpected result: out_byte %0h has_byte %0b finished %0b status %0d",
                           i_out_mon.out_byte, i_out_mon.has_byte, i_out_mon.finished,
                           i_out_mon.status);
                    fails++;
                end else begin
                    want = owed_results.pop_front();
                    if (i_out_mon.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %0h, got %0h", want.out_byte,
                               i_out_mon.out_byte);
                        fails++;
                    end
                    if (i_out_mon.has_byte !== want.has_byte) begin
                        $error("has_byte: expected %0b, got %0b", want.has_byte,
                               i_out_mon.has_byte);
                        fails++;
                    end
                    if (i_out_mon.finished !== want.finished) begin
                        $error("finished: expected %0b, got %0b", want.finished,
                               i_out_mon.finished);
                        fails++;
                    end
                    if (i_out_mon.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status,
                               i_out_mon.status);
                        fails++;
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                decode_byte(i_in_mon.stream_byte, i_in_mon.source_end);
            end
        end
        o_fail_count <= fails;
        o_owed       <= owed_results.size();
    end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import lzfd_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AT     = 60;
    localparam int CALM_AT     = 200;
    localparam int PAUSE_AT    = 150;
    localparam int RANDOM_ITEMS = 240;
    localparam int DRAIN_CYCLES = 60;

    logic i_clk;
    logic i_rst_n;

    lzfd_in_if  in_ch ();
    lzfd_out_if out_ch ();

    int fail_count;
    int owed;
    int n_sent;
    logic calm;
    logic [7:0] src_bytes[$];

    lz77_flagged_decompressor_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    lzfd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_owed       (owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog on cycles without any transfer
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
            else quiet++;
        end
        $display("FAIL");
        $finish;
    end

    // receiver side
    initial begin
        logic held;
        held = 1'b0;
        out_ch.ready = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && n_sent >= HOLD_AT) begin
                held = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.stream_byte <= b;
        in_ch.source_end  <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        n_sent++;
    endtask

    task automatic send_stream();
        foreach (src_bytes[i]) send_byte(src_bytes[i], i == src_bytes.size() - 1);
    endtask

    task automatic wait_all_results();
        do @(posedge i_clk); while (owed != 0);
    endtask

    // well-formed stream; bad_pct sets the odds of a rejected distance per token
    task automatic build_stream(input int unsigned total, input int unsigned bad_pct);
        int unsigned made;
        int unsigned slot;
        int unsigned back_dist;
        int unsigned run;
        logic [15:0] pair;
        logic [7:0]  flags;
        logic [7:0]  grp[$];
        src_bytes.delete();
        src_bytes.push_back(8'($urandom_range(0, 255)));
        src_bytes.push_back(total[7:0]);
        src_bytes.push_back(total[15:8]);
        src_bytes.push_back(total[23:16]);
        made = 0;
        while (made < total) begin
            flags = 8'($urandom_range(0, 255));
            grp.delete();
            for (slot = 0; slot < 8 && made < total; slot++) begin
                if (made < 4096 && $urandom_range(0, 99) < bad_pct) begin
                    flags[7-slot] = 1'b1;
                    back_dist     = $urandom_range(made + 1, 4096);
                    run           = $urandom_range(0, 15);
                    pair          = {run[3:0], 12'(back_dist - 1)};
                    grp.push_back(pair[15:8]);
                    grp.push_back(pair[7:0]);
                    break;
                end else if (made > 0 && $urandom_range(0, 1) == 1) begin
                    flags[7-slot] = 1'b1;
                    back_dist     = $urandom_range(1, (made > 4096) ? 4096 : made);
                    run           = $urandom_range(0, 15);
                    pair          = {run[3:0], 12'(back_dist - 1)};
                    grp.push_back(pair[15:8]);
                    grp.push_back(pair[7:0]);
                    made += run + 3;
                end else begin
                    flags[7-slot] = 1'b0;
                    grp.push_back(8'($urandom_range(0, 255)));
                    made++;
                end
            end
            src_bytes.push_back(flags);
            foreach (grp[i]) src_bytes.push_back(grp[i]);
        end
    endtask

    initial begin
        int unsigned pick;
        int unsigned keep;
        logic paused;
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.stream_byte = 8'h00;
        in_ch.source_end  = 1'b0;
        n_sent            = 0;
        calm              = 1'b0;
        paused            = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // short header
        src_bytes = '{8'h10, 8'h05};
        send_stream();
        // zero length
        src_bytes = '{8'h10, 8'h00, 8'h00, 8'h00};
        send_stream();
        // literal extremes, longest copy clipped at the length, trailing byte ignored
        src_bytes = '{8'h10, 8'h13, 8'h00, 8'h00, 8'h20, 8'h00, 8'hFF, 8'hF0, 8'h00, 8'hA5};
        send_stream();
        // farthest distance rejected, fresh flag byte, then source ends early
        src_bytes = '{8'h10, 8'h03, 8'h00, 8'h00, 8'h80, 8'h0F, 8'hFF, 8'h00, 8'h5A};
        send_stream();

        while (n_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                if ($urandom_range(0, 9) == 0) build_stream($urandom_range(100, 300), 0);
                else build_stream($urandom_range(1, 48), 0);
            end else if (pick < 72) begin
                build_stream($urandom_range(1, 64), 8);
            end else if (pick < 82) begin
                build_stream($urandom_range(1, 48), 4);
                keep = $urandom_range(1, src_bytes.size());
                while (src_bytes.size() > keep) void'(src_bytes.pop_back());
            end else if (pick < 90) begin
                build_stream($urandom_range(1, 32), 0);
                repeat ($urandom_range(1, 4)) src_bytes.push_back(8'($urandom_range(0, 255)));
            end else if (pick < 95) begin
                src_bytes.delete();
                repeat ($urandom_range(1, 12)) src_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
                src_bytes = '{8'($urandom_range(0, 255)), 8'h00, 8'h00, 8'h00};
                repeat ($urandom_range(0, 3)) src_bytes.push_back(8'($urandom_range(0, 255)));
            end
            send_stream();
            if (!paused && n_sent >= PAUSE_AT) begin
                paused = 1'b1;
                in_ch.valid <= 1'b0;
                wait_all_results();
            end
            if (n_sent >= CALM_AT) calm = 1'b1;
        end

        in_ch.valid <= 1'b0;
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && owed == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/lzfd_pkg.sv
rtl/core/lzfd_if.sv
rtl/core/lzfd_hist.sv
rtl/core/lz77_flagged_decompressor_top.sv
dv/lzfd_checker.sv
dv/tb_top.sv
